[rtl/vlbrf_pkg.sv]
package vlbrf_pkg;

  // Field widths fixed by the item format
  localparam int DATA_W  = 64;
  localparam int LEN_W   = 4;
  localparam int OP_W    = 2;
  localparam int COUNT_W = 13;

  // Defaults for the top-level parameters
  localparam int DEF_RING_DEPTH = 4096;
  localparam int DEF_LANE_BYTES = 8;

  // Register reset value and register map
  localparam logic [COUNT_W-1:0] BUF_SIZE_RST = 13'd4096;
  localparam logic               REG_BUF_SIZE = 1'b0;

  // Request codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [DATA_W-1:0]  data_out;
    logic [COUNT_W-1:0] used_bytes;
    logic [COUNT_W-1:0] free_bytes;
  } out_item_t;

endpackage

[rtl/variable_length_byte_ring_fifo_top.sv]
// Byte ring FIFO with variable-length requests.
//
// Requests enter on in_data when start is high and busy is low; busy stays
// low, so one request can be taken every clock. Each request writes or reads
// 0 to LANE_BYTES bytes all or nothing, or only queries the fill state.
// Exactly one result comes back per request on out_data, marked by a
// one-cycle out_valid strobe: the byte banks are read into their registered
// outputs beside stage 1, then the read bytes are realigned into a result
// register. Results arrive in request order and cannot be held off.
// The ring is split into LANE_BYTES byte-wide banks, so the bytes of one
// request always hit distinct banks and the sustained rate is one request
// per cycle.
// The APB port holds buffer_size at byte address 0. Writing it empties the
// ring; sizes of 0 act as 1 and sizes above RING_DEPTH act as RING_DEPTH.
// Reset (rst_n low, synchronous) empties the ring and sets buffer_size to
// 4096. There is no clearing pass: stored bytes are only read once written.
module variable_length_byte_ring_fifo_top
  import vlbrf_pkg::*;
#(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int LANE_BYTES = DEF_LANE_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  output out_item_t   out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ROWS   = (RING_DEPTH + LANE_BYTES - 1) / LANE_BYTES;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LW     = (LANE_BYTES > 1) ? $clog2(LANE_BYTES) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int CW     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int RST_SZ = (RING_DEPTH < 4096) ? RING_DEPTH : 4096;

  // Architectural state
  logic [COUNT_W-1:0] buf_size_r;
  logic [CNT_W-1:0]   size_use_r, size_use_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [LW-1:0]      wlane_r, wlane_nxt, rlane_r, rlane_nxt;
  logic [RW-1:0]      wrow_r, wrow_nxt, rrow_r, rrow_nxt;

  // Stage 1 (bank read in flight)
  logic               s1_valid_r, s1_acc_r, s1_rd_r;
  logic [LW-1:0]      s1_rlane_r;
  logic [LEN_W-1:0]   s1_len_r;
  logic [COUNT_W-1:0] s1_used_r, s1_free_r;

  // Result register
  logic               out_valid_r;
  out_item_t          out_item_r, out_item_nxt;

  logic               cfg_wr, req;
  logic               len_ok, acc, wr_acc, rd_acc;
  logic [CNT_W-1:0]   free_now, fill_upd;
  logic [CW-1:0]      len_cw;
  logic [RW-1:0]      wrow_inc, rrow_inc;
  logic [LEN_W-1:0]   wsum, rsum;
  logic [COUNT_W-1:0] cfg_val;

  logic               bank_wen   [LANE_BYTES];
  logic [RW-1:0]      bank_waddr [LANE_BYTES];
  logic [7:0]         bank_wdata [LANE_BYTES];
  logic [RW-1:0]      bank_raddr [LANE_BYTES];
  logic [7:0]         bank_rdata [LANE_BYTES];

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign req    = start & ~busy;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_BUF_SIZE);
  assign prdata = (paddr[2] == REG_BUF_SIZE) ? 32'(buf_size_r) : 32'd0;

  // Size in use for a new buffer_size value
  assign cfg_val = pwdata[COUNT_W-1:0];
  always_comb begin
    priority if (cfg_val == '0) begin
      size_use_nxt = CNT_W'(1);
    end else if (32'(cfg_val) > RING_DEPTH) begin
      size_use_nxt = CNT_W'(RING_DEPTH);
    end else begin
      size_use_nxt = CNT_W'(cfg_val);
    end
  end

  // Acceptance check
  assign free_now = size_use_r - fill_r;
  assign len_cw   = CW'(in_data.length);
  assign len_ok   = (in_data.length <= LEN_W'(LANE_BYTES));
  always_comb begin
    wr_acc = 1'b0;
    rd_acc = 1'b0;
    acc    = 1'b0;
    unique case (in_data.opcode)
      OP_WRITE: begin
        wr_acc = len_ok && (len_cw <= CW'(free_now));
        acc    = wr_acc;
      end
      OP_READ: begin
        rd_acc = len_ok && (len_cw <= CW'(fill_r));
        acc    = rd_acc;
      end
      OP_QUERY: begin
        acc = 1'b1;
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  // Pointer advance: lane within a row, row wraps over the bank depth
  assign wrow_inc = (wrow_r == RW'(ROWS - 1)) ? '0 : wrow_r + 1'b1;
  assign rrow_inc = (rrow_r == RW'(ROWS - 1)) ? '0 : rrow_r + 1'b1;
  assign wsum     = LEN_W'(wlane_r) + in_data.length;
  assign rsum     = LEN_W'(rlane_r) + in_data.length;

  always_comb begin
    wlane_nxt = wlane_r;
    wrow_nxt  = wrow_r;
    rlane_nxt = rlane_r;
    rrow_nxt  = rrow_r;
    fill_upd  = fill_r;
    if (req && wr_acc) begin
      fill_upd = fill_r + CNT_W'(in_data.length);
      if (wsum >= LEN_W'(LANE_BYTES)) begin
        wlane_nxt = LW'(wsum - LEN_W'(LANE_BYTES));
        wrow_nxt  = wrow_inc;
      end else begin
        wlane_nxt = LW'(wsum);
      end
    end
    if (req && rd_acc) begin
      fill_upd = fill_r - CNT_W'(in_data.length);
      if (rsum >= LEN_W'(LANE_BYTES)) begin
        rlane_nxt = LW'(rsum - LEN_W'(LANE_BYTES));
        rrow_nxt  = rrow_inc;
      end else begin
        rlane_nxt = LW'(rsum);
      end
    end
    fill_nxt = fill_upd;
  end

  // Per-bank addresses: banks below the current lane sit on the next row
  always_comb begin
    logic [LEN_W-1:0] wj;
    for (int b = 0; b < LANE_BYTES; b++) begin
      wj = LEN_W'(b) + ((LW'(b) < wlane_r) ? LEN_W'(LANE_BYTES) : '0) - LEN_W'(wlane_r);
      bank_wen[b]   = req && wr_acc && (wj < in_data.length);
      bank_waddr[b] = (LW'(b) < wlane_r) ? wrow_inc : wrow_r;
      bank_wdata[b] = in_data.data_in[{3'(wj), 3'b000} +: 8];
      bank_raddr[b] = (LW'(b) < rlane_r) ? rrow_inc : rrow_r;
    end
  end

  for (genvar g = 0; g < LANE_BYTES; g++) begin : g_bank
    vlbrf_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_bank (
      .clk   (clk),
      .wen   (bank_wen[g]),
      .waddr (bank_waddr[g]),
      .wdata (bank_wdata[g]),
      .raddr (bank_raddr[g]),
      .rdata (bank_rdata[g])
    );
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= BUF_SIZE_RST;
      size_use_r <= CNT_W'(RST_SZ);
      fill_r     <= '0;
      wlane_r    <= '0;
      wrow_r     <= '0;
      rlane_r    <= '0;
      rrow_r     <= '0;
    end else if (cfg_wr) begin
      buf_size_r <= cfg_val;
      size_use_r <= size_use_nxt;
      fill_r     <= '0;
      wlane_r    <= '0;
      wrow_r     <= '0;
      rlane_r    <= '0;
      rrow_r     <= '0;
    end else begin
      fill_r  <= fill_nxt;
      wlane_r <= wlane_nxt;
      wrow_r  <= wrow_nxt;
      rlane_r <= rlane_nxt;
      rrow_r  <= rrow_nxt;
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req;
    end
    s1_acc_r   <= acc;
    s1_rd_r    <= req && rd_acc;
    s1_rlane_r <= rlane_r;
    s1_len_r   <= in_data.length;
    s1_used_r  <= COUNT_W'(fill_nxt);
    s1_free_r  <= COUNT_W'(size_use_r - fill_nxt);
  end

  // Realign bank outputs so the first byte lands in the low lane
  always_comb begin
    logic [LEN_W-1:0] idx;
    out_item_nxt.accepted   = s1_acc_r;
    out_item_nxt.used_bytes = s1_used_r;
    out_item_nxt.free_bytes = s1_free_r;
    out_item_nxt.data_out   = '0;
    for (int i = 0; i < LANE_BYTES; i++) begin
      idx = LEN_W'(i) + LEN_W'(s1_rlane_r);
      if (idx >= LEN_W'(LANE_BYTES)) begin
        idx = idx - LEN_W'(LANE_BYTES);
      end
      if (s1_rd_r && (LEN_W'(i) < s1_len_r)) begin
        out_item_nxt.data_out[8*i +: 8] = bank_rdata[LW'(idx)];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

[rtl/vlbrf_ram.sv]
module vlbrf_ram
  import vlbrf_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wen,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
